FILE: hdl/swdss_pkg.sv
// Shared types, constants and helpers for the stepper wave-drive speed selector.
// Standalone package: no dependencies.
package swdss_pkg;

  // Width of the step period counter; reload values are resized to it.
  localparam int CNT_W = 16;
  // Configuration registers are all this wide.
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam int TICKS_PER_MS = 1000;
  localparam int MS_SLOW = 10;
  localparam int MS_FAST = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0] speed_t;
  typedef logic [3:0] coil_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_SLOW_RELOAD = 2'd0;
  localparam cfg_idx_t REG_FAST_RELOAD = 2'd1;
  localparam cfg_idx_t REG_DEBOUNCE = 2'd2;

  // Speed codes.
  localparam speed_t SPEED_OFF = 2'd0;
  localparam speed_t SPEED_SLOW = 2'd1;
  localparam speed_t SPEED_FAST = 2'd2;

  localparam cfg_word_t SLOW_RELOAD_RST = CFG_W'(TICKS_PER_MS * MS_SLOW - 1);
  localparam cfg_word_t FAST_RELOAD_RST = CFG_W'(TICKS_PER_MS * MS_FAST - 1);
  localparam cfg_word_t DEBOUNCE_RST = CFG_W'(64);
  localparam cfg_word_t DEBOUNCE_SAT = '1;

  // One-hot coil pattern for each of the four wave-drive phases.
  function automatic coil_t wave_pattern(input logic [1:0] phase);
    coil_t pat;
    case (phase)
      2'd0: pat = 4'b0001;
      2'd1: pat = 4'b0010;
      2'd2: pat = 4'b0100;
      default: pat = 4'b1000;
    endcase
    return pat;
  endfunction

  // Speed sequence OFF -> SLOW -> FAST -> OFF.
  function automatic speed_t next_speed(input speed_t cur);
    speed_t nxt;
    case (cur)
      SPEED_OFF: nxt = SPEED_SLOW;
      SPEED_SLOW: nxt = SPEED_FAST;
      default: nxt = SPEED_OFF;
    endcase
    return nxt;
  endfunction

endpackage

FILE: hdl/stepper_wave_drive_speed_select_core.sv
// Stepper wave-drive controller with push-button speed selection (top level).
// Depends on swdss_pkg for constants, types and the coil pattern table.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | into core | in_valid/in_stall  | in_button_level
//  out_    | from core | out_valid/out_stall| out_coil_drive, out_status_led,
//          |           |                    | out_speed_mode, out_step_taken
//  cfg_    | into core | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Every beat is one time-base tick. The core accepts one beat per clock unless in_stall
// is high, and its result beat appears in the single output register on the next cycle.
// A new beat is accepted while the result register is empty or is being drained in
// the same cycle, so a stall on the output side backs up into in_stall only while a
// result is actually held.
// Synchronous active-low reset restores the default reloads and debounce length,
// puts the speed at OFF, awaits a press, and treats the button as released.
module stepper_wave_drive_speed_select_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_button_level,
  output logic                out_valid,
  input  logic                out_stall,
  output swdss_pkg::coil_t    out_coil_drive,
  output logic                out_status_led,
  output swdss_pkg::speed_t   out_speed_mode,
  output logic                out_step_taken,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  swdss_pkg::cfg_idx_t cfg_index,
  input  swdss_pkg::cfg_word_t cfg_data
);
  import swdss_pkg::*;

  // Configuration registers.
  cfg_word_t slow_reload_r;
  cfg_word_t fast_reload_r;
  cfg_word_t debounce_ticks_r;

  // Tick state.
  speed_t    speed_r, speed_nxt;
  logic [1:0] phase_r, phase_nxt;
  cnt_t      period_r, period_nxt;
  cfg_word_t deb_cnt_r, deb_cnt_nxt;
  logic      deb_busy_r, deb_busy_nxt;
  logic      await_rel_r, await_rel_nxt;
  logic      prev_btn_r;
  coil_t     coil_r, coil_nxt;
  logic      led_r, led_nxt;
  logic      step_nxt;

  // Result register.
  logic      out_valid_r;
  coil_t     out_coil_r;
  logic      out_led_r;
  speed_t    out_speed_r;
  logic      out_step_r;

  logic      in_take;
  cfg_word_t deb_limit;
  cnt_t      reload;
  logic      press;
  logic      release_edge;

  // The result register can take a new beat when empty or draining this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // A debounce length of zero behaves as one tick.
  assign deb_limit = (debounce_ticks_r == '0) ? cfg_word_t'(1) : debounce_ticks_r;
  assign press        = prev_btn_r & ~in_button_level;
  assign release_edge = ~prev_btn_r & in_button_level;

  always_comb begin
    speed_nxt     = speed_r;
    deb_cnt_nxt   = deb_cnt_r;
    deb_busy_nxt  = deb_busy_r;
    await_rel_nxt = await_rel_r;
    led_nxt       = led_r;
    phase_nxt     = phase_r;
    period_nxt    = period_r;
    coil_nxt      = coil_r;
    step_nxt      = 1'b0;

    // Button logic runs first; the motor sees the speed it leaves behind.
    if (deb_busy_r) begin
      if (deb_cnt_r != DEBOUNCE_SAT) begin
        deb_cnt_nxt = deb_cnt_r + cfg_word_t'(1);
      end
      if (deb_cnt_nxt >= deb_limit) begin
        deb_busy_nxt = 1'b0;
        if (await_rel_r && in_button_level) begin
          speed_nxt = next_speed(speed_r);
          led_nxt   = ~led_r;
        end
        await_rel_nxt = ~await_rel_r;
      end
    end else if ((!await_rel_r && press) || (await_rel_r && release_edge)) begin
      deb_busy_nxt = 1'b1;
      deb_cnt_nxt  = '0;
    end

    reload = (speed_nxt == SPEED_SLOW) ? CNT_W'(slow_reload_r) : CNT_W'(fast_reload_r);
    if (speed_nxt == SPEED_OFF) begin
      coil_nxt = '0;
    end else if (period_r >= reload) begin
      // Compare is >= so a reload lowered mid-period steps at once.
      period_nxt = '0;
      coil_nxt   = wave_pattern(phase_r);
      phase_nxt  = phase_r + 2'd1;
      step_nxt   = 1'b1;
    end else begin
      period_nxt = period_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_reload_r    <= SLOW_RELOAD_RST;
      fast_reload_r    <= FAST_RELOAD_RST;
      debounce_ticks_r <= DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLOW_RELOAD: slow_reload_r    <= cfg_data;
        REG_FAST_RELOAD: fast_reload_r    <= cfg_data;
        REG_DEBOUNCE:    debounce_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= SPEED_OFF;
      phase_r     <= '0;
      period_r    <= '0;
      deb_cnt_r   <= '0;
      deb_busy_r  <= 1'b0;
      await_rel_r <= 1'b0;
      prev_btn_r  <= 1'b1;
      coil_r      <= '0;
      led_r       <= 1'b0;
    end else if (in_take) begin
      speed_r     <= speed_nxt;
      phase_r     <= phase_nxt;
      period_r    <= period_nxt;
      deb_cnt_r   <= deb_cnt_nxt;
      deb_busy_r  <= deb_busy_nxt;
      await_rel_r <= await_rel_nxt;
      prev_btn_r  <= in_button_level;
      coil_r      <= coil_nxt;
      led_r       <= led_nxt;
    end
  end

  // Output valid: set by a taken beat, cleared when the result drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload follows the taken beat only, so a stalled result holds still.
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_coil_r  <= coil_nxt;
      out_led_r   <= led_nxt;
      out_speed_r <= speed_nxt;
      out_step_r  <= step_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coil_drive = out_coil_r;
  assign out_status_led = out_led_r;
  assign out_speed_mode = out_speed_r;
  assign out_step_taken = out_step_r;

  // The coils are never driven with more than one phase at a time.
  a_coil_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_coil_drive))
    else $error("coil drive has more than one phase on");

  // A step always shows a coil pattern.
  a_step_coil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_taken |-> out_coil_drive != '0)
    else $error("step reported with coils off");

  // OFF means coils released and no step.
  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_speed_mode == SPEED_OFF |-> out_coil_drive == '0 && !out_step_taken)
    else $error("coil activity while speed is OFF");

  // The speed code never leaves the three defined values.
  a_speed_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_speed_mode != 2'd3)
    else $error("undefined speed code");

  // Backpressure on the input only while a result is held.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule
